/* rtl/c128b_pkg.sv */
package c128b_pkg;

  localparam logic [6:0]  SYM_START_B    = 7'd104;
  localparam logic [6:0]  SYM_STOP       = 7'd106;
  localparam logic [6:0]  SYM_COUNT      = 7'd107;
  localparam logic [7:0]  CHECK_MOD      = 8'd103;
  localparam logic [6:0]  START_CHECK    = 7'd1;     // 104 mod 103
  localparam logic [7:0]  FIRST_PRINT    = 8'h20;
  localparam logic [7:0]  LAST_PRINT     = 8'h7E;
  localparam logic [7:0]  MAX_DATA_RESET = 8'd48;
  localparam logic [3:0]  MOD_NORMAL     = 4'd11;
  localparam logic [3:0]  MOD_STOP       = 4'd13;

  // x mod 103 for x below 2^15: quotient is (x * 20361) >> 21.
  localparam logic [14:0] RECIP_MUL      = 15'd20361;
  localparam int          RECIP_SHIFT    = 21;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONPRINT = 2'd1,
    ST_OVER     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_CHAR,
    PH_CHECK,
    PH_STOP
  } phase_t;

  // One classified character on its way from the front to the back.
  typedef struct packed {
    logic       start;
    status_t    status;
    logic [6:0] value;
    logic       last;
    logic [6:0] term;   // value * position mod 103
  } item_t;

  // Element widths of each symbol, one hex digit per bar or space, first element leftmost.
  localparam logic [23:0] SYM_WIDTHS [0:106] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
    24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
    24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
    24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
    24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
    24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
    24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
    24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
    24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
    24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
    24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
    24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
    24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
    24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
    24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
    24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232, 24'h233111
  };

  // Module pattern of a symbol, right-aligned; the stop symbol gets its trailing bar.
  function automatic logic [12:0] sym_modules(input logic [6:0] sym);
    logic [6:0]  idx;
    logic [23:0] row;
    logic [12:0] bits;
    logic [3:0]  w;
    idx  = (sym < SYM_COUNT) ? sym : 7'd0;
    row  = SYM_WIDTHS[idx];
    bits = '0;
    for (int i = 0; i < 6; i++) begin
      w    = row[23 - 4 * i -: 4];
      bits = bits << w;
      if (i % 2 == 0) begin
        bits = bits | ((13'd1 << w) - 13'd1);
      end
    end
    if (idx == SYM_STOP) begin
      bits = {bits[10:0], 2'b11};
    end
    return bits;
  endfunction

endpackage

/* rtl/c128b_front.sv */
module c128b_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              q_write,
  output c128b_pkg::item_t  q_item,
  input  logic              q_full
);
  import c128b_pkg::*;

  logic [7:0]  max_data_chars;
  logic        in_message;
  logic [7:0]  data_count;

  logic        v1, v2, v3;
  item_t       i1, i2, i3;
  logic [7:0]  w1;
  logic [14:0] p2, p3;
  logic [29:0] mq3;

  logic        adv, accept;
  logic        printable, over, emit;
  logic [7:0]  count_eff;
  logic [7:0]  data_count_next;
  item_t       new_item;
  logic [7:0]  char_value;
  logic [7:0]  quot;
  logic [14:0] rem_raw, rem_fix;

  assign cfg_ready = 1'b1;

  // The whole pipe moves together; it holds only when its last stage cannot enter the queue.
  assign in_stall = v3 && q_full;
  assign adv      = !in_stall;
  assign accept   = in_valid && adv;

  always_comb begin
    count_eff  = in_message ? data_count : 8'd0;
    printable  = (char_code >= FIRST_PRINT) && (char_code <= LAST_PRINT);
    over       = count_eff >= max_data_chars;
    emit       = printable && !over;
    char_value = char_code - FIRST_PRINT;

    new_item.start  = !in_message;
    new_item.last   = last_char;
    new_item.value  = emit ? char_value[6:0] : 7'd0;
    new_item.term   = 7'd0;
    if (!printable) begin
      new_item.status = ST_NONPRINT;
    end else if (over) begin
      new_item.status = ST_OVER;
    end else begin
      new_item.status = ST_OK;
    end

    if (last_char) begin
      data_count_next = 8'd0;
    end else if (emit) begin
      data_count_next = count_eff + 8'd1;
    end else begin
      data_count_next = count_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_chars <= MAX_DATA_RESET;
      in_message     <= 1'b0;
      data_count     <= 8'd0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_data_chars <= cfg_data;
      end
      if (accept) begin
        in_message <= !last_char;
        data_count <= data_count_next;
      end
      if (adv) begin
        v1 <= accept;
        v2 <= v1;
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1  <= new_item;
      w1  <= count_eff + 8'd1;
      i2  <= i1;
      p2  <= {8'd0, i1.value} * {7'd0, w1};
      i3  <= i2;
      p3  <= p2;
      mq3 <= {15'd0, p2} * {15'd0, RECIP_MUL};
    end
  end

  always_comb begin
    quot    = mq3[RECIP_SHIFT +: 8];
    rem_raw = p3 - ({7'd0, quot} * {7'd0, CHECK_MOD});
    rem_fix = (rem_raw >= {7'd0, CHECK_MOD}) ? rem_raw - {7'd0, CHECK_MOD} : rem_raw;
    q_item      = i3;
    q_item.term = rem_fix[6:0];
  end

  assign q_write = v3 && adv;

endmodule

/* rtl/c128b_queue.sv */
module c128b_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  c128b_pkg::item_t  wr_item,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output c128b_pkg::item_t  rd_item
);
  import c128b_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  fill;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = fill == CW'(DEPTH);
  assign not_empty = fill != '0;
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");
`endif

endmodule

/* rtl/c128b_back.sv */
module c128b_back (
  input  logic              clk,
  input  logic              rst,
  input  c128b_pkg::item_t  head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        symbol_value,
  output logic [12:0]       module_bits,
  output logic [3:0]        module_count,
  output logic [1:0]        status,
  output logic              end_of_run,
  output logic              end_of_message
);
  import c128b_pkg::*;

  phase_t      phase, phase_next, eff_phase, step_phase;
  item_t       cur, eff;
  logic [6:0]  acc, acc_next;
  logic [7:0]  acc_sum;
  logic        load, emit;

  logic [6:0]  r_sym;
  status_t     r_status;
  logic        r_eor, r_eom;
  logic [12:0] r_bits;
  logic [3:0]  r_count;

  // The output register takes a new result when empty or when its result is transferred.
  assign load = !out_valid || !out_stall;

  always_comb begin
    if (phase == PH_IDLE) begin
      eff = head;
      if (!head_valid) begin
        eff_phase = PH_IDLE;
      end else if (head.start) begin
        eff_phase = PH_START;
      end else begin
        eff_phase = PH_CHAR;
      end
    end else begin
      eff       = cur;
      eff_phase = phase;
    end
    emit = load && (eff_phase != PH_IDLE);
    pop  = load && (phase == PH_IDLE) && head_valid;
  end

  // Next phase.
  always_comb begin
    unique case (eff_phase)
      PH_IDLE:  step_phase = PH_IDLE;
      PH_START: step_phase = PH_CHAR;
      PH_CHAR:  step_phase = eff.last ? PH_CHECK : PH_IDLE;
      PH_CHECK: step_phase = PH_STOP;
      PH_STOP:  step_phase = PH_IDLE;
      default:  step_phase = PH_IDLE;
    endcase
    phase_next = emit ? step_phase : phase;
  end

  // Result of the current phase and checksum update.
  always_comb begin
    acc_sum  = {1'b0, acc} + {1'b0, eff.term};
    acc_next = acc;
    r_sym    = 7'd0;
    r_status = ST_OK;
    r_eor    = 1'b0;
    r_eom    = 1'b0;
    unique case (eff_phase)
      PH_IDLE: begin
      end
      PH_START: begin
        r_sym    = SYM_START_B;
        acc_next = START_CHECK;
      end
      PH_CHAR: begin
        r_sym    = eff.value;
        r_status = eff.status;
        r_eor    = !eff.last;
        acc_next = (acc_sum >= CHECK_MOD) ? 7'(acc_sum - CHECK_MOD) : acc_sum[6:0];
      end
      PH_CHECK: begin
        r_sym = acc;
      end
      PH_STOP: begin
        r_sym    = SYM_STOP;
        r_eor    = 1'b1;
        r_eom    = 1'b1;
        acc_next = 7'd0;
      end
      default: begin
      end
    endcase
    if (r_status == ST_OK && eff_phase != PH_IDLE) begin
      r_bits  = sym_modules(r_sym);
      r_count = (eff_phase == PH_STOP) ? MOD_STOP : MOD_NORMAL;
    end else begin
      r_bits  = 13'd0;
      r_count = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      acc       <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) begin
        acc <= acc_next;
      end
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      symbol_value   <= r_sym;
      module_bits    <= r_bits;
      module_count   <= r_count;
      status         <= r_status;
      end_of_run     <= r_eor;
      end_of_message <= r_eom;
    end
  end

`ifndef ASSERT_OFF
  a_stop_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_message |-> end_of_run && symbol_value == SYM_STOP
                                    && module_count == MOD_STOP)
    else $error("stop result malformed");
  a_flag_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> module_count == 4'd0 && symbol_value == 7'd0
                                     && !end_of_message)
    else $error("flagged result carries a symbol");
  a_acc_range: assert property (@(posedge clk) disable iff (rst) acc < CHECK_MOD[6:0])
    else $error("checksum out of range");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> phase != PH_IDLE || (out_valid && end_of_run))
    else $error("popped item left no trace");
`endif

endmodule

/* rtl/code128b_symbol_encoder_core.sv */
// A character transferred at the input passes three front stages, the queue and the
// result register before its first result is in the output register.
// The front takes one character per cycle while in_stall is low; the back sends one
// result per cycle while out_stall is low, one to four per character (start, data, check, stop).
// Reset (rst, synchronous) empties pipe and queue, clears the checksum and counters,
// and sets max_data_chars to 48; no clearing pass is needed.
module code128b_symbol_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  symbol_value,
  output logic [12:0] module_bits,
  output logic [3:0]  module_count,
  output logic [1:0]  status,
  output logic        end_of_run,
  output logic        end_of_message
);
  import c128b_pkg::*;

  item_t q_item, head;
  logic  q_write, q_full, head_valid, pop;

  c128b_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .q_write   (q_write),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  c128b_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_write),
    .wr_item   (q_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (head_valid),
    .rd_item   (head)
  );

  c128b_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .symbol_value   (symbol_value),
    .module_bits    (module_bits),
    .module_count   (module_count),
    .status         (status),
    .end_of_run     (end_of_run),
    .end_of_message (end_of_message)
  );

endmodule

/* dv/code128b_checker.sv */
module code128b_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  symbol_value,
  input  logic [12:0] module_bits,
  input  logic [3:0]  module_count,
  input  logic [1:0]  status,
  input  logic        end_of_run,
  input  logic        end_of_message,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import c128b_pkg::*;

  typedef struct packed {
    logic [6:0]  sym;
    logic [12:0] bits;
    logic [3:0]  cnt;
    status_t     st;
    logic        eor;
    logic        eom;
  } symbol_word_t;

  // Bar and space widths per symbol value, one nibble each, leftmost element first.
  localparam logic [23:0] ELEMENT_WIDTHS [0:106] = '{
    24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
    24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
    24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
    24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
    24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
    24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
    24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
    24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
    24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
    24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
    24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
    24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
    24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
    24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
    24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
    24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
    24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
    24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
    24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
    24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
    24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
    24'h211232, 24'h233111
  };

  symbol_word_t pending_symbols[$];
  logic [6:0]   weighted_sum;
  logic [7:0]   chars_taken;
  logic         open_msg;
  logic [7:0]   char_limit;
  int           errors = 0;

  assign fail_count = errors;

  function automatic symbol_word_t emit_symbol(input logic [6:0] s);
    logic [23:0]  row;
    logic [12:0]  acc;
    logic         bar;
    int           w;
    symbol_word_t r;
    row = ELEMENT_WIDTHS[s];
    acc = '0;
    bar = 1'b1;
    // Shift in one module at a time, alternating bar and space elements.
    for (int k = 0; k < 6; k++) begin
      w = int'(row[23 - 4 * k -: 4]);
      for (int m = 0; m < w; m++) begin
        acc = {acc[11:0], bar};
      end
      bar = ~bar;
    end
    r.cnt = MOD_NORMAL;
    if (s == SYM_STOP) begin
      acc   = {acc[10:0], 2'b11};
      r.cnt = MOD_STOP;
    end
    r.sym  = s;
    r.bits = acc;
    r.st   = ST_OK;
    r.eor  = 1'b0;
    r.eom  = (s == SYM_STOP);
    return r;
  endfunction

  function automatic symbol_word_t flagged(input status_t st);
    symbol_word_t r;
    r    = '0;
    r.st = st;
    return r;
  endfunction

  task automatic encode_char(input logic [7:0] c, input logic last);
    symbol_word_t res [4];
    int           n;
    int           v;
    n = 0;
    if (!open_msg) begin
      res[n] = emit_symbol(SYM_START_B);
      n++;
      weighted_sum = 7'(int'(SYM_START_B) % int'(CHECK_MOD));
      chars_taken  = '0;
      open_msg     = 1'b1;
    end
    if (c < FIRST_PRINT || c > LAST_PRINT) begin
      res[n] = flagged(ST_NONPRINT);
      n++;
    end else if (chars_taken >= char_limit) begin
      res[n] = flagged(ST_OVER);
      n++;
    end else begin
      v      = int'(c) - int'(FIRST_PRINT);
      res[n] = emit_symbol(7'(v));
      n++;
      weighted_sum = 7'((int'(weighted_sum) + v * (int'(chars_taken) + 1)) % int'(CHECK_MOD));
      chars_taken  = chars_taken + 8'd1;
    end
    if (last) begin
      res[n] = emit_symbol(weighted_sum);
      n++;
      res[n] = emit_symbol(SYM_STOP);
      n++;
      open_msg     = 1'b0;
      weighted_sum = '0;
      chars_taken  = '0;
    end
    res[n - 1].eor = 1'b1;
    for (int i = 0; i < n; i++) begin
      pending_symbols.push_back(res[i]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_result(input symbol_word_t want);
    if (symbol_value !== want.sym) begin
      report_mismatch($sformatf("symbol_value got %0d expected %0d", symbol_value, want.sym));
    end
    if (module_bits !== want.bits) begin
      report_mismatch($sformatf("module_bits got %h expected %h (symbol %0d)",
                                module_bits, want.bits, want.sym));
    end
    if (module_count !== want.cnt) begin
      report_mismatch($sformatf("module_count got %0d expected %0d", module_count, want.cnt));
    end
    if (status !== want.st) begin
      report_mismatch($sformatf("status got %0d expected %0d", status, want.st));
    end
    if (end_of_run !== want.eor) begin
      report_mismatch($sformatf("end_of_run got %b expected %b", end_of_run, want.eor));
    end
    if (end_of_message !== want.eom) begin
      report_mismatch($sformatf("end_of_message got %b expected %b", end_of_message, want.eom));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_symbols.delete();
      weighted_sum = '0;
      chars_taken  = '0;
      open_msg     = 1'b0;
      char_limit   = MAX_DATA_RESET;
    end else begin
      // Results are retired before the new transfer is predicted in the same cycle.
      if (out_valid && !out_stall) begin
        if (pending_symbols.size() == 0) begin
          report_mismatch("result transfer with no result expected");
        end else begin
          check_result(pending_symbols.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        char_limit = cfg_data;
      end
      if (in_valid && !in_stall) begin
        encode_char(char_code, last_char);
      end
    end
    pending <= pending_symbols.size();
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import c128b_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst            = 1'b1;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code      = '0;
  logic        last_char      = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [6:0]  symbol_value;
  logic [12:0] module_bits;
  logic [3:0]  module_count;
  logic [1:0]  status;
  logic        end_of_run;
  logic        end_of_message;

  int pending;
  int fail_count;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_hold = 0;
  int cycles     = 0;

  code128b_symbol_encoder_core u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .symbol_value   (symbol_value),
    .module_bits    (module_bits),
    .module_count   (module_count),
    .status         (status),
    .end_of_run     (end_of_run),
    .end_of_message (end_of_message)
  );

  code128b_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .symbol_value   (symbol_value),
    .module_bits    (module_bits),
    .module_count   (module_count),
    .status         (status),
    .end_of_run     (end_of_run),
    .end_of_message (end_of_message),
    .pending        (pending),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!out_stall && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_hold <= pick_gap(100) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[code128b_symbol_encoder_core] ERROR");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = pick_gap(gap_pct);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_symbols_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Let the pipeline and the output register settle.
    repeat (8) @(posedge clk);
  endtask

  task automatic load_char_limit(input logic [7:0] lim);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] lim, input int n_items, input int gp, input int sp);
    int         sent;
    int         len;
    bit         ends;
    bit         paused;
    logic [7:0] c;
    wait_symbols_done();
    load_char_limit(lim);
    gap_pct   = gp;
    stall_pct = sp;
    sent      = 0;
    paused    = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any byte, any last flag.
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
        ends = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
          end else begin
            c = 8'($urandom_range(32, 126));
          end
          send_char(c, ends && (i == len - 1));
          sent++;
        end
      end
      if (!paused && sent >= n_items / 2) begin
        wait_symbols_done();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limit: printable extremes, non-printable neighbors, then the terminator.
    send_char(8'h20, 1'b0);
    send_char(8'h7E, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h1F, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h41, 1'b1);
    // A message holding only a rejected character still gets start, check and stop.
    send_char(8'h05, 1'b1);
    send_char(8'h42, 1'b1);
    gap_pct   = 50;
    stall_pct = 40;
    // The last character is itself rejected.
    send_char(8'h78, 1'b0);
    send_char(8'h80, 1'b1);
    wait_symbols_done();

    load_char_limit(8'd1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h63, 1'b1);
    wait_symbols_done();

    // A zero limit drops every printable character.
    load_char_limit(8'd0);
    send_char(8'h5A, 1'b0);
    send_char(8'h71, 1'b1);
    wait_symbols_done();

    load_char_limit(8'd255);
    send_char(8'h7E, 1'b0);
    send_char(8'h7E, 1'b0);
    send_char(8'h20, 1'b1);

    run_phase(MAX_DATA_RESET, 40, 30, 25);
    run_phase(8'd255, 30, 30, 25);
    run_phase(8'd1, 25, 30, 25);
    run_phase(8'd0, 20, 30, 25);
    run_phase(8'($urandom_range(2, 20)), 30, 0, 0);
    run_phase(8'($urandom_range(0, 255)), 30, 40, 40);
    wait_symbols_done();

    if (fail_count == 0) begin
      $display("[code128b_symbol_encoder_core] OK");
    end else begin
      $display("[code128b_symbol_encoder_core] ERROR");
    end
    $finish;
  end

endmodule
